// ----- sv/spel_pkg.sv -----
// ----------------------------------------------------------------------------
// spel_pkg
// shared types, constants and codes of the stopping power energy loss block
// ----------------------------------------------------------------------------
package spel_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_FRAC_BITS   = 16;

    localparam int VAL_W     = 32;
    localparam int FUNC_W    = 2;
    localparam int TIDX_W    = 6;
    localparam int MASS_W    = 8;
    localparam int ECOUNT_W  = 7;
    localparam int STEP_W    = 16;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_THICKNESS = 1'd1;

    localparam logic [ECOUNT_W-1:0] ENTRY_COUNT_RST = 7'd2;
    localparam logic [STEP_W-1:0]   STEP_RST        = 16'd6554;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD     = 2'd0,
        FUNC_RESIDUAL = 2'd1,
        FUNC_INITIAL  = 2'd2
    } func_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_E0,
        S_RD_EL,
        S_CAP_EL,
        S_FWD,
        S_DIV_EPA,
        S_WAIT_EPA,
        S_RANGE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_BIN,
        S_LO_RD,
        S_HI_RD,
        S_HI_CAP,
        S_RATIO,
        S_WAIT_RATIO,
        S_MUL_INTERP,
        S_LOSS,
        S_MUL_CHANGE,
        S_UPDATE,
        S_NEXT,
        S_RES_ZERO,
        S_RES_OK,
        S_RES_ERR
    } state_t;

    typedef enum logic [2:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_IDX,
        ADDR_BIN,
        ADDR_BIN1
    } addr_sel_t;

    typedef enum logic {
        DIV_EPA,
        DIV_RATIO
    } div_sel_t;

    typedef enum logic {
        MUL_INTERP,
        MUL_CHANGE
    } mul_sel_t;

    typedef enum logic [1:0] {
        RATIO_ZERO,
        RATIO_ONE,
        RATIO_DIV
    } ratio_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_OK,
        RES_ERR
    } res_sel_t;

    typedef struct packed {
        logic       cap_in;
        logic       load_we;
        addr_sel_t  addr_sel;
        logic       cap_e0;
        logic       cap_elast;
        logic       div_start;
        div_sel_t   div_sel;
        logic       cap_epa;
        logic       idx_init;
        logic       idx_inc;
        logic       cap_bin;
        logic       cap_lo;
        logic       cap_hi;
        logic       cap_dl;
        logic       cap_ratio;
        ratio_sel_t ratio_sel;
        logic       cap_prod;
        mul_sel_t   mul_sel;
        logic       cap_loss;
        logic       upd_e;
        logic       rem_step;
        logic       res_write;
        res_sel_t   res_sel;
    } spel_cmd_t;

    typedef struct packed {
        logic div_done;
        logic fwd_err;
        logic range_err;
        logic srch_ge;
        logic srch_last;
        logic ratio_zero;
        logic ratio_one;
        logic last_slice;
        logic e_same;
        logic out_full;
    } spel_sts_t;

endpackage

// ----- sv/spel_in_if.sv -----
// ----------------------------------------------------------------------------
// spel_in_if
// input channel: table load and energy compute items
// ----------------------------------------------------------------------------
interface spel_in_if;
    logic                              valid;
    logic                              ready;
    logic [spel_pkg::FUNC_W-1:0]       func;
    logic [spel_pkg::TIDX_W-1:0]       table_index;
    logic [spel_pkg::VAL_W-1:0]        table_energy;
    logic [spel_pkg::VAL_W-1:0]        table_loss;
    logic [spel_pkg::VAL_W-1:0]        energy;
    logic [spel_pkg::VAL_W-1:0]        thickness;
    logic [spel_pkg::MASS_W-1:0]       mass_number;

    modport source (
        output valid, func, table_index, table_energy, table_loss,
               energy, thickness, mass_number,
        input  ready
    );

    modport sink (
        input  valid, func, table_index, table_energy, table_loss,
               energy, thickness, mass_number,
        output ready
    );
endinterface

// ----- sv/spel_out_if.sv -----
// ----------------------------------------------------------------------------
// spel_out_if
// result channel: computed energy and status
// ----------------------------------------------------------------------------
interface spel_out_if;
    logic                        valid;
    logic                        ready;
    logic [spel_pkg::VAL_W-1:0]  energy_result;
    logic                        status;

    modport source (
        output valid, energy_result, status,
        input  ready
    );

    modport sink (
        input  valid, energy_result, status,
        output ready
    );
endinterface

// ----- sv/spel_div.sv -----
// ----------------------------------------------------------------------------
// spel_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module spel_div #(
    parameter int DW = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [DW-1:0]               dividend,
    input  logic [spel_pkg::VAL_W-1:0]  divisor,
    output logic                        done,
    output logic [DW-1:0]               quotient
);
    import spel_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]    q_reg;
    logic [VAL_W-1:0] r_reg;
    logic [VAL_W-1:0] d_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [VAL_W:0]   rs;
    logic             ge;
    logic [VAL_W:0]   diff;

    always_comb
    begin
        rs   = {r_reg, q_reg[DW-1]};
        diff = rs - {1'b0, d_reg};
        ge   = (rs >= {1'b0, d_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DW-2:0], ge};
            r_reg <= ge ? diff[VAL_W-1:0] : rs[VAL_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- sv/spel_ctl.sv -----
// ----------------------------------------------------------------------------
// spel_ctl
// sequencer: load, slice loop, table search, interpolation and result steps
// ----------------------------------------------------------------------------
module spel_ctl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [spel_pkg::FUNC_W-1:0]  in_func,
    input  spel_pkg::spel_sts_t          sts,
    output spel_pkg::spel_cmd_t          cmd,
    output logic                         in_ready
);
    import spel_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    if (in_func == FUNC_LOAD)
                    begin
                        cmd.load_we = 1'b1;
                        state_next  = S_RES_ZERO;
                    end
                    else if (in_func == FUNC_RESIDUAL || in_func == FUNC_INITIAL)
                        state_next = S_RD_E0;
                    else
                        state_next = S_RES_ZERO;
                end
            end
            S_RD_E0:
            begin
                cmd.addr_sel = ADDR_ZERO;
                state_next   = S_RD_EL;
            end
            S_RD_EL:
            begin
                cmd.addr_sel = ADDR_LAST;
                cmd.cap_e0   = 1'b1;
                state_next   = S_CAP_EL;
            end
            S_CAP_EL:
            begin
                cmd.cap_elast = 1'b1;
                state_next    = S_FWD;
            end
            S_FWD:
                state_next = sts.fwd_err ? S_RES_ERR : S_DIV_EPA;
            S_DIV_EPA:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_EPA;
                state_next    = S_WAIT_EPA;
            end
            S_WAIT_EPA:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_epa = 1'b1;
                    state_next  = S_RANGE;
                end
            end
            S_RANGE:
            begin
                if (sts.range_err)
                    state_next = S_RES_ERR;
                else
                begin
                    cmd.idx_init = 1'b1;
                    state_next   = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                cmd.addr_sel = ADDR_IDX;
                state_next   = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (sts.srch_ge)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = sts.srch_last ? S_BIN : S_SRCH_RD;
                end
                else
                    state_next = S_BIN;
            end
            S_BIN:
            begin
                cmd.cap_bin = 1'b1;
                state_next  = S_LO_RD;
            end
            S_LO_RD:
            begin
                cmd.addr_sel = ADDR_BIN;
                state_next   = S_HI_RD;
            end
            S_HI_RD:
            begin
                cmd.addr_sel = ADDR_BIN1;
                cmd.cap_lo   = 1'b1;
                state_next   = S_HI_CAP;
            end
            S_HI_CAP:
            begin
                cmd.cap_hi = 1'b1;
                state_next = S_RATIO;
            end
            S_RATIO:
            begin
                cmd.cap_dl = 1'b1;
                priority if (sts.ratio_zero)
                begin
                    cmd.cap_ratio = 1'b1;
                    cmd.ratio_sel = RATIO_ZERO;
                    state_next    = S_MUL_INTERP;
                end
                else if (sts.ratio_one)
                begin
                    cmd.cap_ratio = 1'b1;
                    cmd.ratio_sel = RATIO_ONE;
                    state_next    = S_MUL_INTERP;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_RATIO;
                    state_next    = S_WAIT_RATIO;
                end
            end
            S_WAIT_RATIO:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_ratio = 1'b1;
                    cmd.ratio_sel = RATIO_DIV;
                    state_next    = S_MUL_INTERP;
                end
            end
            S_MUL_INTERP:
            begin
                cmd.cap_prod = 1'b1;
                cmd.mul_sel  = MUL_INTERP;
                state_next   = S_LOSS;
            end
            S_LOSS:
            begin
                cmd.cap_loss = 1'b1;
                state_next   = S_MUL_CHANGE;
            end
            S_MUL_CHANGE:
            begin
                cmd.cap_prod = 1'b1;
                cmd.mul_sel  = MUL_CHANGE;
                state_next   = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.upd_e  = 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (sts.last_slice || sts.e_same)
                    state_next = S_RES_OK;
                else
                begin
                    cmd.rem_step = 1'b1;
                    state_next   = S_DIV_EPA;
                end
            end
            S_RES_ZERO:
            begin
                if (!sts.out_full)
                begin
                    cmd.res_write = 1'b1;
                    cmd.res_sel   = RES_ZERO;
                    state_next    = S_IDLE;
                end
            end
            S_RES_OK:
            begin
                if (!sts.out_full)
                begin
                    cmd.res_write = 1'b1;
                    cmd.res_sel   = RES_OK;
                    state_next    = S_IDLE;
                end
            end
            S_RES_ERR:
            begin
                if (!sts.out_full)
                begin
                    cmd.res_write = 1'b1;
                    cmd.res_sel   = RES_ERR;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ----- sv/spel_dp.sv -----
// ----------------------------------------------------------------------------
// spel_dp
// datapath: table memory, configuration, energy and slice registers,
// shared divider and multiplier, result register
// ----------------------------------------------------------------------------
module spel_dp #(
    parameter int TABLE_DEPTH = spel_pkg::DEF_TABLE_DEPTH,
    parameter int FRAC_BITS   = spel_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spel_pkg::spel_cmd_t               cmd,
    output spel_pkg::spel_sts_t               sts,
    input  logic                              cfg_we,
    input  logic [spel_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [spel_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [spel_pkg::FUNC_W-1:0]       func,
    input  logic [spel_pkg::TIDX_W-1:0]       table_index,
    input  logic [spel_pkg::VAL_W-1:0]        table_energy,
    input  logic [spel_pkg::VAL_W-1:0]        table_loss,
    input  logic [spel_pkg::VAL_W-1:0]        energy,
    input  logic [spel_pkg::VAL_W-1:0]        thickness,
    input  logic [spel_pkg::MASS_W-1:0]       mass_number,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [spel_pkg::VAL_W-1:0]        energy_result,
    output logic                              status
);
    import spel_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int DW    = VAL_W + FRAC_BITS;
    localparam int RW    = FRAC_BITS + 1;
    localparam int PW    = 2 * VAL_W;

    // configuration
    logic [ECOUNT_W-1:0] ecount_reg;
    logic [STEP_W-1:0]   step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecount_reg <= ENTRY_COUNT_RST;
            step_reg   <= STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENTRY_COUNT:    ecount_reg <= cfg_data[ECOUNT_W-1:0];
                CFG_STEP_THICKNESS: step_reg   <= cfg_data[STEP_W-1:0];
                default:            ;
            endcase
        end
    end

    logic [CNT_W-1:0]  n_used;
    logic [STEP_W-1:0] step_eff;

    always_comb
    begin
        if (ecount_reg < ECOUNT_W'(2))
            n_used = CNT_W'(2);
        else if (32'(ecount_reg) > 32'(TABLE_DEPTH))
            n_used = CNT_W'(TABLE_DEPTH);
        else
            n_used = CNT_W'(ecount_reg);
        step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;
    end

    // table memory, energy in the upper half, loss in the lower
    logic [2*VAL_W-1:0] mem [TABLE_DEPTH];
    logic [2*VAL_W-1:0] rd_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [VAL_W-1:0]   rd_e;
    logic [VAL_W-1:0]   rd_l;

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] bin_reg;
    logic [CNT_W-1:0] n_last;
    logic [CNT_W-1:0] bin1;

    always_comb
    begin
        n_last = n_used - 1'b1;
        bin1   = bin_reg + 1'b1;
        unique case (cmd.addr_sel)
            ADDR_ZERO: rd_addr = '0;
            ADDR_LAST: rd_addr = n_last[IDX_W-1:0];
            ADDR_IDX:  rd_addr = idx_reg[IDX_W-1:0];
            ADDR_BIN:  rd_addr = bin_reg[IDX_W-1:0];
            ADDR_BIN1: rd_addr = bin1[IDX_W-1:0];
            default:   rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && (32'(table_index) < 32'(TABLE_DEPTH)))
            mem[IDX_W'(table_index)] <= {table_energy, table_loss};
        rd_reg <= mem[rd_addr];
    end

    assign rd_e = rd_reg[2*VAL_W-1:VAL_W];
    assign rd_l = rd_reg[VAL_W-1:0];

    // item and slice state
    logic               fwd_reg;
    logic [VAL_W-1:0]   e_reg;
    logic [VAL_W-1:0]   before_reg;
    logic [VAL_W-1:0]   rem_reg;
    logic [MASS_W-1:0]  a_reg;
    logic [VAL_W-1:0]   e0_reg;
    logic [VAL_W-1:0]   elast_reg;
    logic [VAL_W-1:0]   epa_reg;
    logic [VAL_W-1:0]   lo_e_reg;
    logic [VAL_W-1:0]   lo_l_reg;
    logic [VAL_W-1:0]   hi_e_reg;
    logic [VAL_W-1:0]   hi_l_reg;
    logic               up_reg;
    logic [VAL_W-1:0]   dl_reg;
    logic [RW-1:0]      ratio_reg;
    logic [VAL_W-1:0]   loss_reg;
    logic [PW-1:0]      prod_reg;

    logic [STEP_W-1:0]  slice;
    logic [CNT_W-1:0]   idx_m1;
    logic [CNT_W-1:0]   n_m2;
    logic [VAL_W-1:0]   part;
    logic [VAL_W-1:0]   change;
    logic [VAL_W-1:0]   mul_a;
    logic [VAL_W-1:0]   mul_b;
    logic [PW-1:0]      mul_p;

    always_comb
    begin
        slice  = (rem_reg < VAL_W'(step_eff)) ? rem_reg[STEP_W-1:0] : step_eff;
        idx_m1 = idx_reg - 1'b1;
        n_m2   = n_used - CNT_W'(2);
        part   = prod_reg[FRAC_BITS+VAL_W-1:FRAC_BITS];
        change = prod_reg[FRAC_BITS+VAL_W-1:FRAC_BITS];
        unique case (cmd.mul_sel)
            MUL_INTERP:
            begin
                mul_a = dl_reg;
                mul_b = VAL_W'(ratio_reg);
            end
            MUL_CHANGE:
            begin
                mul_a = loss_reg;
                mul_b = VAL_W'(slice);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = {{VAL_W{1'b0}}, mul_a} * {{VAL_W{1'b0}}, mul_b};
    end

    // shared divider
    logic [DW-1:0]    div_dividend;
    logic [VAL_W-1:0] div_divisor;
    logic             div_done;
    logic [DW-1:0]    div_q;

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_EPA:
            begin
                div_dividend = DW'(e_reg);
                div_divisor  = VAL_W'(a_reg);
            end
            DIV_RATIO:
            begin
                div_dividend = {epa_reg - lo_e_reg, {FRAC_BITS{1'b0}}};
                div_divisor  = hi_e_reg - lo_e_reg;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    spel_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            fwd_reg <= (func == FUNC_RESIDUAL);
            e_reg   <= energy;
            rem_reg <= thickness;
            a_reg   <= (mass_number == '0) ? MASS_W'(1) : mass_number;
        end
        else
        begin
            if (cmd.upd_e)
            begin
                before_reg <= e_reg;
                if (fwd_reg)
                    e_reg <= (change > e_reg) ? '0 : e_reg - change;
                else
                    e_reg <= (change > ~e_reg) ? '1 : e_reg + change;
            end
            if (cmd.rem_step)
                rem_reg <= rem_reg - VAL_W'(step_eff);
        end
        if (cmd.cap_e0)
            e0_reg <= rd_e;
        if (cmd.cap_elast)
            elast_reg <= rd_e;
        if (cmd.cap_epa)
            epa_reg <= div_q[VAL_W-1:0];
        if (cmd.idx_init)
            idx_reg <= CNT_W'(1);
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + 1'b1;
        if (cmd.cap_bin)
            bin_reg <= (idx_m1 > n_m2) ? n_m2 : idx_m1;
        if (cmd.cap_lo)
        begin
            lo_e_reg <= rd_e;
            lo_l_reg <= rd_l;
        end
        if (cmd.cap_hi)
        begin
            hi_e_reg <= rd_e;
            hi_l_reg <= rd_l;
        end
        if (cmd.cap_dl)
        begin
            up_reg <= (hi_l_reg >= lo_l_reg);
            dl_reg <= (hi_l_reg >= lo_l_reg) ? hi_l_reg - lo_l_reg : lo_l_reg - hi_l_reg;
        end
        if (cmd.cap_ratio)
        begin
            unique case (cmd.ratio_sel)
                RATIO_ZERO: ratio_reg <= '0;
                RATIO_ONE:  ratio_reg <= {1'b1, {FRAC_BITS{1'b0}}};
                RATIO_DIV:  ratio_reg <= div_q[RW-1:0];
                default:    ratio_reg <= '0;
            endcase
        end
        if (cmd.cap_prod)
            prod_reg <= mul_p;
        if (cmd.cap_loss)
            loss_reg <= up_reg ? lo_l_reg + part : lo_l_reg - part;
    end

    // result register
    logic             out_valid_reg;
    logic [VAL_W-1:0] res_reg;
    logic             status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.res_write)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_write)
        begin
            unique case (cmd.res_sel)
                RES_OK:
                begin
                    res_reg    <= e_reg;
                    status_reg <= 1'b0;
                end
                RES_ERR:
                begin
                    res_reg    <= '0;
                    status_reg <= 1'b1;
                end
                default:
                begin
                    res_reg    <= '0;
                    status_reg <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign energy_result = res_reg;
    assign status        = status_reg;

    always_comb
    begin
        sts.div_done   = div_done;
        sts.fwd_err    = fwd_reg && (e_reg > elast_reg);
        sts.range_err  = (epa_reg < e0_reg) || (epa_reg > elast_reg);
        sts.srch_ge    = (epa_reg >= rd_e);
        sts.srch_last  = ({1'b0, idx_reg} + 1'b1) >= {1'b0, n_used};
        sts.ratio_zero = (epa_reg <= lo_e_reg);
        sts.ratio_one  = (epa_reg >= hi_e_reg);
        sts.last_slice = (VAL_W'(slice) == rem_reg);
        sts.e_same     = (e_reg == before_reg);
        sts.out_full   = out_valid_reg && !out_ready;
    end

    // no result overwritten while one still waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_write |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten");

    // search reads stay inside the entries in use
    a_search_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.addr_sel == ADDR_IDX) |-> (idx_reg < n_used))
        else $error("search index beyond table");

    // interpolation bin always has an upper neighbor
    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cap_bin |=> ({1'b0, bin_reg} + 2'd2 <= {1'b0, n_used}))
        else $error("bin beyond last pair");

    // ratio never above one
    a_ratio_max: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cap_ratio |=> (ratio_reg <= {1'b1, {FRAC_BITS{1'b0}}}))
        else $error("ratio above one");

endmodule

// ----- sv/stopping_power_energy_loss.sv -----
// ----------------------------------------------------------------------------
// stopping_power_energy_loss
// energy loss in an absorber by linear interpolation in a stopping power table
// ----------------------------------------------------------------------------
// in_ch carries one beat per item: func selects a table load, a residual
// energy or an initial energy computation. out_ch returns one beat per item
// with energy_result and status. Configuration registers entry_count and
// step_thickness are written through cfg_we, cfg_index and cfg_data.
// A load result is written to the output register in the result state that
// follows the load beat, once that register is free. A compute item runs the
// setup states S_RD_E0, S_RD_EL, S_CAP_EL and S_FWD, one pass per absorber
// slice and a result state. Each pass gets the per-nucleon energy from the
// bit-serial divider, scans table entries through the single table read port
// and, unless the ratio needs no division, divides again for the ratio.
// Items are taken one at a time; a new item is accepted as soon as the
// previous result sits in the output register, even while it is not taken.
// While the receiver stalls, the result holds and a finished following item
// waits for the output register.
// Reset returns the sequencer to idle, empties the output register and sets
// entry_count to 2 and step_thickness to 6554; table contents are undefined
// until loaded.
// ----------------------------------------------------------------------------
module stopping_power_energy_loss #(
    parameter int TABLE_DEPTH = spel_pkg::DEF_TABLE_DEPTH,
    parameter int FRAC_BITS   = spel_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    spel_in_if.sink                           in_ch,
    spel_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [spel_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [spel_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import spel_pkg::*;

    spel_cmd_t cmd;
    spel_sts_t sts;

    spel_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_func  (in_ch.func),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ch.ready)
    );

    spel_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (in_ch.func),
        .table_index   (in_ch.table_index),
        .table_energy  (in_ch.table_energy),
        .table_loss    (in_ch.table_loss),
        .energy        (in_ch.energy),
        .thickness     (in_ch.thickness),
        .mass_number   (in_ch.mass_number),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .energy_result (out_ch.energy_result),
        .status        (out_ch.status)
    );

endmodule
